### rtl/hbr_pkg.sv
// ----------------------------------------------------------------------------
// hbr_pkg
// Types and fixed constants shared by the hue band recolor pipeline.
// ----------------------------------------------------------------------------
package hbr_pkg;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET    = 2'd2;

   localparam int CFG_W = 15;
   localparam logic [CFG_W-1:0] BAND_LOW_RESET  = 15'd960;
   localparam logic [CFG_W-1:0] BAND_HIGH_RESET = 15'd2880;
   localparam logic [CFG_W-1:0] TARGET_RESET    = 15'd12480;

   // Reciprocals for exact floor division by 60 and by 360 over the
   // value ranges that reach them (below 2^14 and 2^15 respectively).
   localparam logic [14:0] RECIP_60        = 15'd17477;
   localparam int          RECIP_60_SHIFT  = 20;
   localparam logic [15:0] RECIP_360       = 16'd46604;
   localparam int          RECIP_360_SHIFT = 24;

   // Which channel holds the maximum; ties go red first, then green.
   typedef enum logic [1:0] {
      SEL_RED,
      SEL_GREEN,
      SEL_BLUE
   } sel_type;

   // Sixty-degree hue sectors of the replacement hue.
   typedef enum logic [2:0] {
      SEC_RED_YELLOW,
      SEC_YELLOW_GREEN,
      SEC_GREEN_CYAN,
      SEC_CYAN_BLUE,
      SEC_BLUE_MAGENTA,
      SEC_MAGENTA_RED
   } sector_type;

   typedef struct packed {
      logic [7:0] blue_in;
      logic [7:0] green_in;
      logic [7:0] red_in;
      logic [7:0] alpha_in;
      logic       frame_end_in;
   } req_type;

   typedef struct packed {
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
      logic [7:0] alpha_out;
      logic       recolored;
      logic       frame_end_out;
   } rsp_type;

   // Per-pixel context that travels down the pipeline with the pixel.
   typedef struct packed {
      req_type    px;
      logic [7:0] mx;
      logic [7:0] mn;
      sel_type    sel;
      logic       neg;
      logic       gray;
   } ctx_type;

endpackage

### rtl/hbr_div.sv
// ----------------------------------------------------------------------------
// hbr_div
// Pipelined restoring divider, one quotient bit per stage. Divides the
// hue numerator by the channel spread (max - min) of the pixel context.
// ----------------------------------------------------------------------------
module hbr_div #(
   parameter int QUO_W = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  hbr_pkg::ctx_type  in_ctx,
   input  logic [7:0]        in_rem,
   input  logic [QUO_W-1:0]  in_num,
   output logic              out_valid,
   input  logic              out_ready,
   output hbr_pkg::ctx_type  out_ctx,
   output logic [QUO_W-1:0]  out_quo,
   output logic [7:0]        out_rem
);

   logic             stage_valid [QUO_W];
   logic             stage_ready [QUO_W];
   hbr_pkg::ctx_type stage_ctx   [QUO_W];
   logic [7:0]       stage_rem   [QUO_W];
   logic [QUO_W-1:0] stage_nq    [QUO_W];

   genvar i;
   generate
      for (i = 0; i < QUO_W; i++) begin : g_step
         logic             src_valid;
         hbr_pkg::ctx_type src_ctx;
         logic [7:0]       src_rem;
         logic [QUO_W-1:0] src_nq;
         logic             down_ready;
         logic [8:0]       rem_sh;
         logic [8:0]       div_ext;
         logic             take;
         logic [7:0]       rem_in;
         logic [QUO_W-1:0] nq_in;
         logic             valid_ff;
         hbr_pkg::ctx_type ctx_ff;
         logic [7:0]       rem_ff;
         logic [QUO_W-1:0] nq_ff;

         if (i == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_ctx   = in_ctx;
            assign src_rem   = in_rem;
            assign src_nq    = in_num;
         end else begin : g_next
            assign src_valid = stage_valid[i-1];
            assign src_ctx   = stage_ctx[i-1];
            assign src_rem   = stage_rem[i-1];
            assign src_nq    = stage_nq[i-1];
         end

         if (i == QUO_W - 1) begin : g_last
            assign down_ready = out_ready;
         end else begin : g_mid
            assign down_ready = stage_ready[i+1];
         end

         // The numerator bits shift out at the top while quotient bits
         // shift in at the bottom, so the word ends up as the quotient.
         assign rem_sh  = {src_rem, src_nq[QUO_W-1]};
         assign div_ext = {1'b0, src_ctx.mx - src_ctx.mn};
         assign take    = (rem_sh >= div_ext);
         assign rem_in  = take ? 8'(rem_sh - div_ext) : rem_sh[7:0];
         assign nq_in   = {src_nq[QUO_W-2:0], take};

         assign stage_ready[i] = ~valid_ff | down_ready;

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff <= 1'b0;
            end else if (stage_ready[i]) begin
               valid_ff <= src_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (stage_ready[i]) begin
               ctx_ff <= src_ctx;
               rem_ff <= rem_in;
               nq_ff  <= nq_in;
            end
         end

         assign stage_valid[i] = valid_ff;
         assign stage_ctx[i]   = ctx_ff;
         assign stage_rem[i]   = rem_ff;
         assign stage_nq[i]    = nq_ff;
      end
   endgenerate

   assign in_ready  = stage_ready[0];
   assign out_valid = stage_valid[QUO_W-1];
   assign out_ctx   = stage_ctx[QUO_W-1];
   assign out_quo   = stage_nq[QUO_W-1];
   assign out_rem   = stage_rem[QUO_W-1];

endmodule

### rtl/hue_band_recolor.sv
// ----------------------------------------------------------------------------
// hue_band_recolor
// Per-pixel HSL hue band replacement on a BGRA pixel stream.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and returns one pixel per clock while
// the result side is not stalled, in order. QB = clog2(60 * 2^HUE_FRAC_BITS + 1)
// is the number of stages of the pipelined hue divider (12 stages at the
// default of six fraction bits). The divider, which produces one quotient bit
// per stage, sets the depth. Every stage holds its own valid bit, so bubbles
// close up and a stall on the result side does not stop input until the
// pipeline is full. Configuration writes are taken in any cycle but must only
// be issued while no pixel is in flight; after a write the replacement-hue
// decode settles through its product, degree, sector and multiplier registers.
// ----------------------------------------------------------------------------
module hue_band_recolor #(
   parameter int HUE_FRAC_BITS = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  hbr_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output hbr_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hbr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hbr_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int HUE_ONE   = 1 << HUE_FRAC_BITS;
   localparam int HUE_SIXTY = 60 * HUE_ONE;
   localparam int HUE_FULL  = 360 * HUE_ONE;
   localparam int QB        = $clog2(HUE_SIXTY + 1);
   localparam int NB        = QB + 8;
   localparam int HW        = $clog2(HUE_FULL);
   localparam int HW1       = HW + 1;
   localparam int CMPW      = (HW > hbr_pkg::CFG_W) ? HW : hbr_pkg::CFG_W;
   localparam int MPW       = QB + 8;

   localparam logic [HW:0]   HUE_FULL_W = HW1'(HUE_FULL);
   localparam logic [HW:0]   HUE_120_W  = HW1'(120 * HUE_ONE);
   localparam logic [HW:0]   HUE_240_W  = HW1'(240 * HUE_ONE);
   localparam logic [QB-1:0] SIXTY_Q    = QB'(HUE_SIXTY);
   localparam logic [14:0]   FRAC_MASK  = 15'(HUE_ONE - 1);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [hbr_pkg::CFG_W-1:0] band_low_ff;
   logic [hbr_pkg::CFG_W-1:0] band_high_ff;
   logic [hbr_pkg::CFG_W-1:0] target_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_low_ff  <= hbr_pkg::BAND_LOW_RESET;
         band_high_ff <= hbr_pkg::BAND_HIGH_RESET;
         target_ff    <= hbr_pkg::TARGET_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hbr_pkg::CSR_BAND_LOW:  band_low_ff  <= csr_wdata;
            hbr_pkg::CSR_BAND_HIGH: band_high_ff <= csr_wdata;
            hbr_pkg::CSR_TARGET:    target_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Replacement hue decode: sector and position inside the sector.
   // Runs every cycle from the static target register.
   // ------------------------------------------------------------------
   logic [14:0]         tgt_deg;
   logic [30:0]         kprod_ff;
   logic [6:0]          turns;
   logic [8:0]          tdeg_in;
   logic [8:0]          tdeg_ff;
   logic [2:0]          sec_in;
   logic [5:0]          pofs;
   logic [QB-1:0]       ppos_in;
   hbr_pkg::sector_type sec_ff;
   logic [QB-1:0]       ppos_ff;
   logic [QB-1:0]       pmul_ff;

   assign tgt_deg = 15'(target_ff >> HUE_FRAC_BITS);
   assign turns   = 7'(kprod_ff >> hbr_pkg::RECIP_360_SHIFT);
   assign tdeg_in = 9'(tgt_deg - 15'(turns) * 15'd360);

   always_comb begin
      sec_in = 3'(tdeg_ff >= 9'd60) + 3'(tdeg_ff >= 9'd120) + 3'(tdeg_ff >= 9'd180)
             + 3'(tdeg_ff >= 9'd240) + 3'(tdeg_ff >= 9'd300);
      pofs    = 6'(tdeg_ff - 9'(sec_in) * 9'd60);
      ppos_in = QB'((QB'(pofs) << HUE_FRAC_BITS) | QB'(target_ff & FRAC_MASK));
   end

   always_ff @(posedge clock) begin
      kprod_ff <= 31'(tgt_deg) * 31'(hbr_pkg::RECIP_360);
      tdeg_ff  <= tdeg_in;
      sec_ff   <= hbr_pkg::sector_type'(sec_in);
      ppos_ff  <= ppos_in;
      // Odd sectors run the middle channel downward.
      pmul_ff  <= sec_ff[0] ? SIXTY_Q - ppos_ff : ppos_ff;
   end

   // ------------------------------------------------------------------
   // Stage A: max, min, dominant channel and hue numerator sign.
   // ------------------------------------------------------------------
   logic             a_ready;
   logic             a_valid_ff;
   hbr_pkg::ctx_type a_ctx_in;
   hbr_pkg::ctx_type a_ctx_ff;
   logic [7:0]       a_absn_in;
   logic [7:0]       a_absn_ff;
   logic [8:0]       a_n9;
   logic [7:0]       red_v;
   logic [7:0]       green_v;
   logic [7:0]       blue_v;

   always_comb begin
      red_v   = req_data.red_in;
      green_v = req_data.green_in;
      blue_v  = req_data.blue_in;
      a_ctx_in.px = req_data;
      a_ctx_in.mx = red_v;
      if (green_v > a_ctx_in.mx) a_ctx_in.mx = green_v;
      if (blue_v > a_ctx_in.mx) a_ctx_in.mx = blue_v;
      a_ctx_in.mn = red_v;
      if (green_v < a_ctx_in.mn) a_ctx_in.mn = green_v;
      if (blue_v < a_ctx_in.mn) a_ctx_in.mn = blue_v;
      if (a_ctx_in.mx == red_v) begin
         a_ctx_in.sel = hbr_pkg::SEL_RED;
      end else if (a_ctx_in.mx == green_v) begin
         a_ctx_in.sel = hbr_pkg::SEL_GREEN;
      end else begin
         a_ctx_in.sel = hbr_pkg::SEL_BLUE;
      end
      case (a_ctx_in.sel)
         hbr_pkg::SEL_RED:   a_n9 = {1'b0, green_v} - {1'b0, blue_v};
         hbr_pkg::SEL_GREEN: a_n9 = {1'b0, blue_v} - {1'b0, red_v};
         default:            a_n9 = {1'b0, red_v} - {1'b0, green_v};
      endcase
      a_ctx_in.neg  = a_n9[8];
      a_ctx_in.gray = (a_ctx_in.mx == a_ctx_in.mn);
      a_absn_in     = a_n9[8] ? 8'(-a_n9) : a_n9[7:0];
   end

   // ------------------------------------------------------------------
   // Stage B: scale the numerator by sixty degrees.
   // ------------------------------------------------------------------
   logic             b_ready;
   logic             b_valid_ff;
   hbr_pkg::ctx_type b_ctx_ff;
   logic [NB-1:0]    b_num_in;
   logic [7:0]       b_rem_ff;
   logic [QB-1:0]    b_low_ff;

   assign b_num_in = NB'(a_absn_ff) * NB'(HUE_SIXTY);

   // ------------------------------------------------------------------
   // Divider and stages after it
   // ------------------------------------------------------------------
   logic             div_in_ready;
   logic             div_valid;
   hbr_pkg::ctx_type div_ctx;
   logic [QB-1:0]    div_quo;
   logic [7:0]       div_rem;

   logic             h_ready;
   logic             h_valid_ff;
   hbr_pkg::ctx_type h_ctx_ff;
   logic [HW:0]      h_base;
   logic [QB:0]      h_qc;
   logic [HW:0]      h_sum;
   logic [HW-1:0]    h_hue_in;
   logic [HW-1:0]    h_hue_ff;

   logic             c_ready;
   logic             c_valid_ff;
   hbr_pkg::ctx_type c_ctx_ff;
   logic             c_band_in;
   logic             c_band_ff;

   logic             m_ready;
   logic             m_valid_ff;
   hbr_pkg::ctx_type m_ctx_ff;
   logic             m_band_ff;
   logic [MPW-1:0]   m_prod;
   logic [13:0]      m_y_in;
   logic [13:0]      m_y_ff;

   logic             r_ready;
   logic             r_valid_ff;
   hbr_pkg::ctx_type r_ctx_ff;
   logic             r_band_ff;
   logic [28:0]      r_prod;
   logic [7:0]       r_x_in;
   logic [7:0]       r_x_ff;

   logic             o_ready;
   logic             o_valid_ff;
   hbr_pkg::rsp_type o_rsp_in;
   hbr_pkg::rsp_type o_rsp_ff;
   logic [7:0]       o_mid;

   assign o_ready   = ~o_valid_ff | rsp_ready;
   assign r_ready   = ~r_valid_ff | o_ready;
   assign m_ready   = ~m_valid_ff | r_ready;
   assign c_ready   = ~c_valid_ff | m_ready;
   assign h_ready   = ~h_valid_ff | c_ready;
   assign b_ready   = ~b_valid_ff | div_in_ready;
   assign a_ready   = ~a_valid_ff | b_ready;
   assign req_ready = a_ready;

   hbr_div #(
      .QUO_W (QB)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_ff),
      .in_ready  (div_in_ready),
      .in_ctx    (b_ctx_ff),
      .in_rem    (b_rem_ff),
      .in_num    (b_low_ff),
      .out_valid (div_valid),
      .out_ready (h_ready),
      .out_ctx   (div_ctx),
      .out_quo   (div_quo),
      .out_rem   (div_rem)
   );

   // Hue assembly. A negative offset takes the floor, so a nonzero
   // remainder adds one to the magnitude being subtracted.
   always_comb begin
      case (div_ctx.sel)
         hbr_pkg::SEL_RED:   h_base = div_ctx.neg ? HUE_FULL_W : '0;
         hbr_pkg::SEL_GREEN: h_base = HUE_120_W;
         default:            h_base = HUE_240_W;
      endcase
      h_qc     = {1'b0, div_quo} + (QB+1)'(div_rem != 8'd0);
      h_sum    = div_ctx.neg ? h_base - HW1'(h_qc) : h_base + HW1'(div_quo);
      h_hue_in = div_ctx.gray ? '0 : h_sum[HW-1:0];
   end

   assign c_band_in = (h_ctx_ff.px.alpha_in != 8'd0)
                   && (CMPW'(h_hue_ff) >= CMPW'(band_low_ff))
                   && (CMPW'(h_hue_ff) <= CMPW'(band_high_ff));

   assign m_prod = MPW'(c_ctx_ff.mx - c_ctx_ff.mn) * MPW'(pmul_ff);
   assign m_y_in = 14'(m_prod >> HUE_FRAC_BITS);
   assign r_prod = 29'(m_y_ff) * 29'(hbr_pkg::RECIP_60);
   assign r_x_in = 8'(r_prod >> hbr_pkg::RECIP_60_SHIFT);

   always_comb begin
      o_mid = r_ctx_ff.mn + r_x_ff;
      o_rsp_in.alpha_out     = r_ctx_ff.px.alpha_in;
      o_rsp_in.frame_end_out = r_ctx_ff.px.frame_end_in;
      o_rsp_in.recolored     = r_band_ff;
      if (r_band_ff) begin
         case (sec_ff)
            hbr_pkg::SEC_RED_YELLOW: begin
               o_rsp_in.red_out   = r_ctx_ff.mx;
               o_rsp_in.green_out = o_mid;
               o_rsp_in.blue_out  = r_ctx_ff.mn;
            end
            hbr_pkg::SEC_YELLOW_GREEN: begin
               o_rsp_in.red_out   = o_mid;
               o_rsp_in.green_out = r_ctx_ff.mx;
               o_rsp_in.blue_out  = r_ctx_ff.mn;
            end
            hbr_pkg::SEC_GREEN_CYAN: begin
               o_rsp_in.red_out   = r_ctx_ff.mn;
               o_rsp_in.green_out = r_ctx_ff.mx;
               o_rsp_in.blue_out  = o_mid;
            end
            hbr_pkg::SEC_CYAN_BLUE: begin
               o_rsp_in.red_out   = r_ctx_ff.mn;
               o_rsp_in.green_out = o_mid;
               o_rsp_in.blue_out  = r_ctx_ff.mx;
            end
            hbr_pkg::SEC_BLUE_MAGENTA: begin
               o_rsp_in.red_out   = o_mid;
               o_rsp_in.green_out = r_ctx_ff.mn;
               o_rsp_in.blue_out  = r_ctx_ff.mx;
            end
            default: begin
               o_rsp_in.red_out   = r_ctx_ff.mx;
               o_rsp_in.green_out = r_ctx_ff.mn;
               o_rsp_in.blue_out  = o_mid;
            end
         endcase
      end else begin
         o_rsp_in.red_out   = r_ctx_ff.px.red_in;
         o_rsp_in.green_out = r_ctx_ff.px.green_in;
         o_rsp_in.blue_out  = r_ctx_ff.px.blue_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage valid bits
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= req_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (h_ready) h_valid_ff <= div_valid;
         if (c_ready) c_valid_ff <= h_valid_ff;
         if (m_ready) m_valid_ff <= c_valid_ff;
         if (r_ready) r_valid_ff <= m_valid_ff;
         if (o_ready) o_valid_ff <= r_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage payloads
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_ctx_ff  <= a_ctx_in;
         a_absn_ff <= a_absn_in;
      end
      if (b_ready) begin
         b_ctx_ff <= a_ctx_ff;
         b_rem_ff <= b_num_in[NB-1:QB];
         b_low_ff <= b_num_in[QB-1:0];
      end
      if (h_ready) begin
         h_ctx_ff <= div_ctx;
         h_hue_ff <= h_hue_in;
      end
      if (c_ready) begin
         c_ctx_ff  <= h_ctx_ff;
         c_band_ff <= c_band_in;
      end
      if (m_ready) begin
         m_ctx_ff  <= c_ctx_ff;
         m_band_ff <= c_band_ff;
         m_y_ff    <= m_y_in;
      end
      if (r_ready) begin
         r_ctx_ff  <= m_ctx_ff;
         r_band_ff <= m_band_ff;
         r_x_ff    <= r_x_in;
      end
      if (o_ready) begin
         o_rsp_ff <= o_rsp_in;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_rsp_ff;

endmodule

### rtl/hbr_check.sv
// ----------------------------------------------------------------------------
// hbr_check
// Port-level checks for the hue band recolor block, bound to the top level.
// ----------------------------------------------------------------------------
module hbr_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input hbr_pkg::rsp_type                rsp_data,
   input logic                            csr_valid,
   input logic                            csr_ready
);

   logic [5:0] outstanding_ff;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // Pixels accepted whose result transfer has not yet happened.
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + 6'(req_xfer) - 6'(rsp_xfer);
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outstanding_ff != 6'd0))
      else $error("result offered with no pixel in flight");

   a_opaque_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.recolored) |-> (rsp_data.alpha_out != 8'd0))
      else $error("transparent pixel reported as recolored");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or dropped");

   // Register writes are only allowed while the pipeline is empty.
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> (outstanding_ff == 6'd0))
      else $error("register written with pixels in flight");

endmodule

bind hue_band_recolor hbr_check u_hbr_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
